// ===== src/cpa_pkg.sv =====
// Shared types, codes and constants of the column partition allocator.
package cpa_pkg;

  localparam int MaxColumns    = 32;
  localparam int MaxRequests   = 16;
  localparam int MaxCandidates = 8;

  localparam int IdW      = 64;
  localparam int ColCntW  = 6;
  localparam int ColW     = 5;
  localparam int QosW     = 16;
  localparam int StatusW  = 3;
  localparam int ActionW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;
  localparam int EffW     = 8;
  localparam int TopClkW  = 12;

  // Request stream packing, lowest bit first.
  localparam int RidLsb   = 0;
  localparam int NcolLsb  = RidLsb + IdW;
  localparam int StartLsb = NcolLsb + ColCntW;
  localparam int OpsLsb   = StartLsb + ColW;
  localparam int LatLsb   = OpsLsb + QosW;
  localparam int FpsLsb   = LatLsb + QosW;
  localparam int GopsLsb  = FpsLsb + QosW;
  localparam int InBits   = GopsLsb + QosW;
  localparam int InDataW  = ((InBits + 7) / 8) * 8;

  // Result stream packing, lowest bit first.
  localparam int StatusLsb = 0;
  localparam int ResIdLsb  = StatusLsb + StatusW;
  localparam int PstartLsb = ResIdLsb + IdW;
  localparam int PwidthLsb = PstartLsb + ColW;
  localparam int OutBits   = PwidthLsb + ColCntW;
  localparam int OutDataW  = ((OutBits + 7) / 8) * 8;

  // Frame-rate numerator of the latency term.
  localparam int RateDividend = 1000;
  localparam int QuotW        = 10;
  localparam int ScaleConst   = 1000;

  localparam logic CmdRelease = 1'b1;

  typedef enum logic [2:0] {
    ST_OK, ST_INVALID, ST_ID_IN_USE, ST_NO_PART, ST_NOT_FOUND, ST_TABLE_FULL
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_LOAD, ACT_UNLOAD
  } action_e;

  typedef enum logic [1:0] {
    CFG_TOTAL_COLUMNS, CFG_EFFICIENCY, CFG_TOP_CLOCK, CFG_SHARE_MODE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_QOS, CS_RSCAN, CS_RDONE, CS_CSCAN, CS_PSCAN, CS_PDONE,
    CS_PRD, CS_PREL, CS_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    QP_IDLE, QP_DIV, QP_MUL1, QP_MUL2, QP_CMP
  } qos_phase_e;

  typedef struct packed {
    logic            start;
    logic [QosW-1:0] ops;
    logic [QosW-1:0] latency;
    logic [QosW-1:0] fps;
    logic [QosW-1:0] gops;
  } qos_req_t;

  typedef struct packed {
    logic done;
    logic invalid;
  } qos_status_t;

  function automatic int idx_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== src/cpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module cpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [cpa_pkg::idx_w(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]                   wdata_i,
  input  logic [cpa_pkg::idx_w(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]                   rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/cpa_qos.sv =====
// QoS admission unit: iterative latency divide, then registered products and compare.
module cpa_qos (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cpa_pkg::qos_req_t                  req_i,
  input  logic [cpa_pkg::EffW-1:0]           eff_i,
  input  logic [cpa_pkg::TopClkW-1:0]        top_clock_i,
  output cpa_pkg::qos_status_t               status_o
);

  localparam int QW   = cpa_pkg::QosW;
  localparam int P1W  = 2 * QW;
  localparam int NW   = P1W + cpa_pkg::EffW;
  localparam int CW   = QW + cpa_pkg::TopClkW;
  localparam int SW   = NW + 10;
  localparam logic [cpa_pkg::QuotW-1:0] Dividend = cpa_pkg::QuotW'(cpa_pkg::RateDividend);

  cpa_pkg::qos_phase_e       phase_q, phase_d;
  logic [QW-1:0]             ops_q, lat_q, fps_q, gops_q;
  logic [QW:0]               rem_q, trial;
  logic [cpa_pkg::QuotW-1:0] quo_q;
  logic [3:0]                bit_q;
  logic [P1W-1:0]            prod1_q;
  logic [NW-1:0]             need_q;
  logic [CW-1:0]             cap_q;
  logic [QW-1:0]             rate;
  logic [SW-1:0]             scaled;
  logic                      done_q, invalid_q;

  assign trial  = {rem_q[QW-1:0], Dividend[bit_q]};
  assign rate   = (lat_q == '0) ? fps_q :
                  ((QW'(quo_q) > fps_q) ? QW'(quo_q) : fps_q);
  // need * 1000 as shifted sums.
  assign scaled = {need_q, 10'b0} - SW'({need_q, 4'b0}) - SW'({need_q, 3'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cpa_pkg::QP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      cpa_pkg::QP_IDLE: if (req_i.start) phase_d = cpa_pkg::QP_DIV;
      cpa_pkg::QP_DIV:  if (bit_q == '0) phase_d = cpa_pkg::QP_MUL1;
      cpa_pkg::QP_MUL1: phase_d = cpa_pkg::QP_MUL2;
      cpa_pkg::QP_MUL2: phase_d = cpa_pkg::QP_CMP;
      cpa_pkg::QP_CMP:  phase_d = cpa_pkg::QP_IDLE;
      default:          phase_d = cpa_pkg::QP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (phase_q == cpa_pkg::QP_CMP);
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      cpa_pkg::QP_IDLE: begin
        ops_q  <= req_i.ops;
        lat_q  <= req_i.latency;
        fps_q  <= req_i.fps;
        gops_q <= req_i.gops;
        rem_q  <= '0;
        quo_q  <= '0;
        bit_q  <= 4'(cpa_pkg::QuotW - 1);
      end
      cpa_pkg::QP_DIV: begin
        if (trial >= {1'b0, lat_q}) begin
          rem_q <= trial - {1'b0, lat_q};
          quo_q <= {quo_q[cpa_pkg::QuotW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[cpa_pkg::QuotW-2:0], 1'b0};
        end
        bit_q <= bit_q - 4'd1;
      end
      cpa_pkg::QP_MUL1: prod1_q <= rate * gops_q;
      cpa_pkg::QP_MUL2: begin
        need_q <= prod1_q * eff_i;
        cap_q  <= ops_q * top_clock_i;
      end
      cpa_pkg::QP_CMP: invalid_q <= SW'(cap_q) < scaled;
      default: ;
    endcase
  end

  assign status_o.done    = done_q;
  assign status_o.invalid = invalid_q;

endmodule

// ===== src/column_partition_allocator.sv =====
// Top level of the column partition allocator: control sequencer, tables and stream ports.
// Sequence: a plain candidate item is only stored; a release scans the request table, then
//   reads and frees the partition; an allocation runs the QoS check (a 10-step latency divide),
//   the request table scan and the candidate scan, plus a partition table scan in sharing mode;
//   the table scans test one entry per cycle.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset clears control state, valid bits, column map and configuration to their defaults.
module column_partition_allocator #(
  parameter int MAX_COLUMNS    = cpa_pkg::MaxColumns,
  parameter int MAX_REQUESTS   = cpa_pkg::MaxRequests,
  parameter int MAX_CANDIDATES = cpa_pkg::MaxCandidates
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // request_id, column_count, start_column, ops_per_cycle, latency, frames_per_second, giga_ops
  input  logic [cpa_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,   // last_start
  input  logic                           s_axis_tuser_i,   // command
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status, request_id_res, partition_start, partition_width
  output logic [cpa_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic [cpa_pkg::ActionW-1:0]    m_axis_tuser_o,   // action
  input  logic                           cfg_we_i,
  input  logic [cpa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cpa_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int IdW    = cpa_pkg::IdW;
  localparam int CcW    = cpa_pkg::ColCntW;
  localparam int ColW   = cpa_pkg::ColW;
  localparam int PIDX_W = cpa_pkg::idx_w(MAX_COLUMNS);
  localparam int RIDX_W = cpa_pkg::idx_w(MAX_REQUESTS);
  localparam int CIDX_W = cpa_pkg::idx_w(MAX_CANDIDATES);
  localparam int CCNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int PCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int SHR_W  = $clog2(MAX_REQUESTS + 1);
  localparam int MAXALL = (MAX_COLUMNS > MAX_REQUESTS) ?
                          ((MAX_COLUMNS > MAX_CANDIDATES) ? MAX_COLUMNS : MAX_CANDIDATES) :
                          ((MAX_REQUESTS > MAX_CANDIDATES) ? MAX_REQUESTS : MAX_CANDIDATES);
  localparam int CNT_W  = $clog2(MAXALL + 1);
  // Request table entry: {partition index, id}.
  localparam int REQ_W  = IdW + PIDX_W;
  // Partition record: {sharers, exclusive, width, start}.
  localparam int WID_LSB = ColW;
  localparam int EXC_BIT = ColW + CcW;
  localparam int SHR_LSB = EXC_BIT + 1;
  localparam int PREC_W  = SHR_LSB + SHR_W;

  cpa_pkg::ctrl_state_e state_q, state_d;

  // Configuration registers.
  logic [CcW-1:0]               tot_cols_q;
  logic [cpa_pkg::EffW-1:0]     eff_q;
  logic [cpa_pkg::TopClkW-1:0]  top_clk_q;
  logic                         share_q;

  // Column map, valid bits and age ranks.
  logic [MAX_COLUMNS-1:0]       col_map_q;
  logic [MAX_REQUESTS-1:0]      req_valid_q;
  logic [MAX_COLUMNS-1:0]       part_valid_q;
  logic [PIDX_W-1:0]            stamp_q [MAX_COLUMNS];
  logic [PCNT_W-1:0]            stamp_cnt_q;

  // Candidate run.
  logic [ColW-1:0]              cand_q [MAX_CANDIDATES];
  logic [CCNT_W-1:0]            cand_cnt_q;

  // Current request.
  logic                         rel_q;
  logic [IdW-1:0]               rid_q;
  logic [CcW-1:0]               ncols_q;
  logic                         excl_q;
  logic [CNT_W-1:0]             scan_q;
  logic [CNT_W-1:0]             prev_idx;

  logic                         hit_q;
  logic [RIDX_W-1:0]            hit_idx_q;
  logic [PIDX_W-1:0]            hit_part_q;

  logic                         have_q;
  logic [PIDX_W-1:0]            best_idx_q;
  logic [ColW-1:0]              best_start_q;
  logic [SHR_W-1:0]             best_sh_q;
  logic [PIDX_W-1:0]            best_stamp_q;

  logic [cpa_pkg::StatusW-1:0]  res_status_q;
  logic [cpa_pkg::ActionW-1:0]  res_action_q;
  logic [ColW-1:0]              res_start_q;
  logic [CcW-1:0]               res_width_q;

  logic                         out_valid_q;
  logic [cpa_pkg::OutDataW-1:0] out_data_q;
  logic [cpa_pkg::ActionW-1:0]  out_user_q;

  // Memory ports.
  logic                         req_we;
  logic [RIDX_W-1:0]            req_waddr, req_raddr;
  logic [REQ_W-1:0]             req_wdata, req_rdata;
  logic                         part_we;
  logic [PIDX_W-1:0]            part_waddr, part_raddr;
  logic [PREC_W-1:0]            part_wdata, part_rdata;

  cpa_pkg::qos_req_t            qos_req;
  cpa_pkg::qos_status_t         qos_st;

  logic                         in_accept;
  logic [ColW-1:0]              cur_cand;
  logic [ColW-1:0]              span_col;
  logic [CcW-1:0]               span_w;
  logic [CcW:0]                 span_end;
  logic [MAX_COLUMNS-1:0]       span;
  logic                         fit;
  logic                         req_free;
  logic [RIDX_W-1:0]            req_free_idx;
  logic                         part_free;
  logic [PIDX_W-1:0]            part_free_idx;
  logic [ColW-1:0]              rec_start;
  logic [CcW-1:0]               rec_width;
  logic                         rec_excl;
  logic [SHR_W-1:0]             rec_sh;
  logic [SHR_W-1:0]             rel_sh;
  logic                         in_list;
  logic                         share_ok;
  logic [PIDX_W-1:0]            stamp_idx;
  logic [PIDX_W-1:0]            stamp_rd;
  logic                         out_free;
  logic                         drop_part;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == cpa_pkg::CS_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign prev_idx        = scan_q - CNT_W'(1);

  assign rec_start = part_rdata[ColW-1:0];
  assign rec_width = part_rdata[WID_LSB +: CcW];
  assign rec_excl  = part_rdata[EXC_BIT];
  assign rec_sh    = part_rdata[SHR_LSB +: SHR_W];
  assign rel_sh    = (rec_sh != '0) ? rec_sh - SHR_W'(1) : '0;
  assign drop_part = part_valid_q[hit_part_q] && (rel_sh == '0);

  assign cur_cand = cand_q[scan_q[CIDX_W-1:0]];

  // One column span per cycle: the candidate under test or the partition being freed.
  always_comb begin
    span_col = (state_q == cpa_pkg::CS_PREL) ? rec_start : cur_cand;
    span_w   = (state_q == cpa_pkg::CS_PREL) ? rec_width : ncols_q;
    span_end = {1'b0, CcW'(span_col)} + {1'b0, span_w};
    for (int b = 0; b < MAX_COLUMNS; b++) begin
      span[b] = (b >= int'(span_col)) && (b < int'(span_end));
    end
    fit = (int'(span_end) <= MAX_COLUMNS) && ((span & col_map_q) == '0);
  end

  // Lowest free request slot and partition slot.
  always_comb begin
    req_free     = 1'b0;
    req_free_idx = '0;
    for (int i = MAX_REQUESTS - 1; i >= 0; i--) begin
      if (!req_valid_q[i]) begin
        req_free     = 1'b1;
        req_free_idx = RIDX_W'(i);
      end
    end
    part_free     = 1'b0;
    part_free_idx = '0;
    for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
      if (!part_valid_q[i]) begin
        part_free     = 1'b1;
        part_free_idx = PIDX_W'(i);
      end
    end
  end

  // A shared partition must start at one of the run's candidate columns.
  always_comb begin
    in_list = 1'b0;
    for (int k = 0; k < MAX_CANDIDATES; k++) begin
      if ((k < int'(cand_cnt_q)) && (cand_q[k] == rec_start)) in_list = 1'b1;
    end
  end

  assign stamp_idx = (state_q == cpa_pkg::CS_PSCAN) ? prev_idx[PIDX_W-1:0] : hit_part_q;
  assign stamp_rd  = stamp_q[stamp_idx];

  assign share_ok = (scan_q != '0) && part_valid_q[prev_idx[PIDX_W-1:0]] && !rec_excl &&
                    (rec_width == ncols_q) && in_list &&
                    (!have_q || (rec_sh < best_sh_q) ||
                     ((rec_sh == best_sh_q) && (stamp_rd < best_stamp_q)));

  // QoS unit starts on the last item of an allocate run.
  always_comb begin
    qos_req.start   = in_accept && (s_axis_tuser_i != cpa_pkg::CmdRelease) && s_axis_tlast_i;
    qos_req.ops     = s_axis_tdata_i[cpa_pkg::OpsLsb  +: cpa_pkg::QosW];
    qos_req.latency = s_axis_tdata_i[cpa_pkg::LatLsb  +: cpa_pkg::QosW];
    qos_req.fps     = s_axis_tdata_i[cpa_pkg::FpsLsb  +: cpa_pkg::QosW];
    qos_req.gops    = s_axis_tdata_i[cpa_pkg::GopsLsb +: cpa_pkg::QosW];
  end

  cpa_qos u_qos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (qos_req),
    .eff_i       (eff_q),
    .top_clock_i (top_clk_q),
    .status_o    (qos_st)
  );

  // Table writes happen only at the end of a request, after all of its reads,
  // so no read ever overlaps a pending write to the same entry.
  always_comb begin
    req_raddr  = scan_q[RIDX_W-1:0];
    req_we     = 1'b0;
    req_waddr  = req_free_idx;
    req_wdata  = {part_free_idx, rid_q};
    part_raddr = (state_q == cpa_pkg::CS_PSCAN) ? scan_q[PIDX_W-1:0] : hit_part_q;
    part_we    = 1'b0;
    part_waddr = part_free_idx;
    part_wdata = {SHR_W'(1), excl_q, ncols_q, cur_cand};
    case (state_q)
      cpa_pkg::CS_CSCAN: begin
        if ((CCNT_W'(scan_q) < cand_cnt_q) && fit && part_free) begin
          req_we  = 1'b1;
          part_we = 1'b1;
        end
      end
      cpa_pkg::CS_PDONE: begin
        if (have_q) begin
          req_we     = 1'b1;
          req_wdata  = {best_idx_q, rid_q};
          part_we    = 1'b1;
          part_waddr = best_idx_q;
          part_wdata = {best_sh_q + SHR_W'(1), 1'b0, ncols_q, best_start_q};
        end
      end
      cpa_pkg::CS_PREL: begin
        if (part_valid_q[hit_part_q]) begin
          part_we    = 1'b1;
          part_waddr = hit_part_q;
          part_wdata = {rel_sh, rec_excl, rec_width, rec_start};
        end
      end
      default: ;
    endcase
  end

  cpa_ram #(.Width(REQ_W), .Depth(MAX_REQUESTS)) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (req_we),
    .waddr_i (req_waddr),
    .wdata_i (req_wdata),
    .raddr_i (req_raddr),
    .rdata_o (req_rdata)
  );

  cpa_ram #(.Width(PREC_W), .Depth(MAX_COLUMNS)) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (part_we),
    .waddr_i (part_waddr),
    .wdata_i (part_wdata),
    .raddr_i (part_raddr),
    .rdata_o (part_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpa_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpa_pkg::CS_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser_i == cpa_pkg::CmdRelease) state_d = cpa_pkg::CS_RSCAN;
          else if (s_axis_tlast_i)                   state_d = cpa_pkg::CS_QOS;
        end
      end
      cpa_pkg::CS_QOS: begin
        if (qos_st.done) begin
          if (qos_st.invalid || (ncols_q > tot_cols_q)) state_d = cpa_pkg::CS_OUT;
          else                                          state_d = cpa_pkg::CS_RSCAN;
        end
      end
      cpa_pkg::CS_RSCAN: begin
        if (int'(scan_q) == MAX_REQUESTS) state_d = cpa_pkg::CS_RDONE;
      end
      cpa_pkg::CS_RDONE: begin
        if (rel_q)                  state_d = hit_q ? cpa_pkg::CS_PRD : cpa_pkg::CS_OUT;
        else if (hit_q || !req_free) state_d = cpa_pkg::CS_OUT;
        else                        state_d = cpa_pkg::CS_CSCAN;
      end
      cpa_pkg::CS_CSCAN: begin
        if (CCNT_W'(scan_q) >= cand_cnt_q) begin
          state_d = share_q ? cpa_pkg::CS_PSCAN : cpa_pkg::CS_OUT;
        end else if (fit) begin
          state_d = cpa_pkg::CS_OUT;
        end
      end
      cpa_pkg::CS_PSCAN: begin
        if (int'(scan_q) == MAX_COLUMNS) state_d = cpa_pkg::CS_PDONE;
      end
      cpa_pkg::CS_PDONE: state_d = cpa_pkg::CS_OUT;
      cpa_pkg::CS_PRD:   state_d = cpa_pkg::CS_PREL;
      cpa_pkg::CS_PREL:  state_d = cpa_pkg::CS_OUT;
      cpa_pkg::CS_OUT:   if (out_free) state_d = cpa_pkg::CS_IDLE;
      default:           state_d = cpa_pkg::CS_IDLE;
    endcase
  end

  // Configuration, valid bits, map and age ranks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_cols_q   <= CcW'(32);
      eff_q        <= cpa_pkg::EffW'(1);
      top_clk_q    <= cpa_pkg::TopClkW'(1000);
      share_q      <= 1'b0;
      col_map_q    <= '0;
      req_valid_q  <= '0;
      part_valid_q <= '0;
      stamp_cnt_q  <= '0;
      cand_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cpa_pkg::cfg_idx_e'(cfg_idx_i))
          cpa_pkg::CFG_TOTAL_COLUMNS: tot_cols_q <= cfg_data_i[CcW-1:0];
          cpa_pkg::CFG_EFFICIENCY:    eff_q      <= cfg_data_i[cpa_pkg::EffW-1:0];
          cpa_pkg::CFG_TOP_CLOCK:     top_clk_q  <= cfg_data_i[cpa_pkg::TopClkW-1:0];
          cpa_pkg::CFG_SHARE_MODE:    share_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_accept && (s_axis_tuser_i != cpa_pkg::CmdRelease) &&
          (int'(cand_cnt_q) < MAX_CANDIDATES)) begin
        cand_cnt_q <= cand_cnt_q + CCNT_W'(1);
      end
      if ((state_q == cpa_pkg::CS_OUT) && !rel_q && out_free) begin
        cand_cnt_q <= '0;
      end
      if (state_q == cpa_pkg::CS_CSCAN && (CCNT_W'(scan_q) < cand_cnt_q) && fit &&
          part_free) begin
        col_map_q                   <= col_map_q | span;
        part_valid_q[part_free_idx] <= 1'b1;
        stamp_cnt_q                 <= stamp_cnt_q + PCNT_W'(1);
      end
      if (req_we) begin
        req_valid_q[req_free_idx] <= 1'b1;
      end
      if (state_q == cpa_pkg::CS_PREL) begin
        req_valid_q[hit_idx_q] <= 1'b0;
        if (drop_part) begin
          col_map_q                <= col_map_q & ~span;
          part_valid_q[hit_part_q] <= 1'b0;
          if (stamp_cnt_q != '0) stamp_cnt_q <= stamp_cnt_q - PCNT_W'(1);
        end
      end
      if ((state_q == cpa_pkg::CS_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Age ranks: a new partition takes the next rank, and ranks above a freed one close up.
  always_ff @(posedge clk_i) begin
    for (int q = 0; q < MAX_COLUMNS; q++) begin
      if ((state_q == cpa_pkg::CS_CSCAN) && (CCNT_W'(scan_q) < cand_cnt_q) && fit &&
          part_free && (PIDX_W'(q) == part_free_idx)) begin
        stamp_q[q] <= stamp_cnt_q[PIDX_W-1:0];
      end else if ((state_q == cpa_pkg::CS_PREL) && drop_part && part_valid_q[q] &&
                   (stamp_q[q] > stamp_rd)) begin
        stamp_q[q] <= stamp_q[q] - PIDX_W'(1);
      end
    end
  end

  // Request fields, scans and result.
  always_ff @(posedge clk_i) begin
    if (in_accept && (s_axis_tuser_i != cpa_pkg::CmdRelease) &&
        (int'(cand_cnt_q) < MAX_CANDIDATES)) begin
      cand_q[cand_cnt_q[CIDX_W-1:0]] <= s_axis_tdata_i[cpa_pkg::StartLsb +: ColW];
    end
    case (state_q)
      cpa_pkg::CS_IDLE: begin
        rel_q   <= (s_axis_tuser_i == cpa_pkg::CmdRelease);
        rid_q   <= s_axis_tdata_i[cpa_pkg::RidLsb +: IdW];
        ncols_q <= s_axis_tdata_i[cpa_pkg::NcolLsb +: CcW];
        excl_q  <= (s_axis_tdata_i[cpa_pkg::LatLsb +: cpa_pkg::QosW] != '0);
        scan_q  <= '0;
        hit_q   <= 1'b0;
        have_q  <= 1'b0;
      end
      cpa_pkg::CS_QOS: begin
        res_status_q <= cpa_pkg::ST_INVALID;
        res_action_q <= cpa_pkg::ACT_NONE;
        res_start_q  <= '0;
        res_width_q  <= '0;
      end
      cpa_pkg::CS_RSCAN: begin
        scan_q <= scan_q + CNT_W'(1);
        if ((scan_q != '0) && req_valid_q[prev_idx[RIDX_W-1:0]] &&
            (req_rdata[IdW-1:0] == rid_q)) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= prev_idx[RIDX_W-1:0];
          hit_part_q <= req_rdata[IdW +: PIDX_W];
        end
      end
      cpa_pkg::CS_RDONE: begin
        scan_q       <= '0;
        res_action_q <= cpa_pkg::ACT_NONE;
        res_start_q  <= '0;
        res_width_q  <= '0;
        if (rel_q)         res_status_q <= hit_q ? cpa_pkg::ST_OK : cpa_pkg::ST_NOT_FOUND;
        else if (hit_q)    res_status_q <= cpa_pkg::ST_ID_IN_USE;
        else               res_status_q <= cpa_pkg::ST_TABLE_FULL;
      end
      cpa_pkg::CS_CSCAN: begin
        if (CCNT_W'(scan_q) >= cand_cnt_q) begin
          scan_q       <= '0;
          res_status_q <= cpa_pkg::ST_NO_PART;
        end else if (fit) begin
          if (part_free) begin
            res_status_q <= cpa_pkg::ST_OK;
            res_action_q <= cpa_pkg::ACT_LOAD;
            res_start_q  <= cur_cand;
            res_width_q  <= ncols_q;
          end else begin
            res_status_q <= cpa_pkg::ST_TABLE_FULL;
          end
        end else begin
          scan_q <= scan_q + CNT_W'(1);
        end
      end
      cpa_pkg::CS_PSCAN: begin
        scan_q <= scan_q + CNT_W'(1);
        if (share_ok) begin
          have_q       <= 1'b1;
          best_idx_q   <= prev_idx[PIDX_W-1:0];
          best_start_q <= rec_start;
          best_sh_q    <= rec_sh;
          best_stamp_q <= stamp_rd;
        end
      end
      cpa_pkg::CS_PDONE: begin
        if (have_q) begin
          res_status_q <= cpa_pkg::ST_OK;
          res_action_q <= cpa_pkg::ACT_LOAD;
          res_start_q  <= best_start_q;
          res_width_q  <= ncols_q;
        end
      end
      cpa_pkg::CS_PREL: begin
        res_status_q <= cpa_pkg::ST_OK;
        res_action_q <= cpa_pkg::ACT_UNLOAD;
        res_start_q  <= rec_start;
        res_width_q  <= rec_width;
      end
      cpa_pkg::CS_OUT: begin
        if (out_free) begin
          out_data_q <= cpa_pkg::OutDataW'({res_width_q, res_start_q, rid_q, res_status_q});
          out_user_q <= res_action_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== src/cpa_checker.sv =====
// Port-level checks of the column partition allocator, bound to the top level.
module cpa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [cpa_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [cpa_pkg::ActionW-1:0]  m_axis_tuser_o
);

  logic [cpa_pkg::StatusW-1:0] status;
  logic [cpa_pkg::ColW-1:0]    pstart;
  logic [cpa_pkg::ColCntW-1:0] pwidth;

  assign status = m_axis_tdata_o[cpa_pkg::StatusLsb +: cpa_pkg::StatusW];
  assign pstart = m_axis_tdata_o[cpa_pkg::PstartLsb +: cpa_pkg::ColW];
  assign pwidth = m_axis_tdata_o[cpa_pkg::PwidthLsb +: cpa_pkg::ColCntW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_fail_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status != cpa_pkg::ST_OK) |-> m_axis_tuser_o == cpa_pkg::ACT_NONE)
    else $error("failed request carries an action");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == cpa_pkg::ACT_NONE) |-> pstart == '0 && pwidth == '0)
    else $error("partition fields set without an action");

  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == cpa_pkg::CmdRelease) |=>
      !s_axis_tready_o)
    else $error("new request taken during a release lookup");

endmodule

bind column_partition_allocator cpa_checker u_cpa_checker (.*);
